// ===== rtl/bhpq_pkg.sv =====
// Shared types, codes and the key ordering function of the binary heap priority queue.
// Standalone package; used by bhpq_sift_cmp and binary_heap_priority_queue.
package bhpq_pkg;

  // Default number of keys the store holds.
  localparam int DEF_CAPACITY = 1024;

  // Field widths fixed by the item formats.
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 11;

  // Operation codes carried by func.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Status codes of a result.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // One input item.
  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key_in;
  } bhpq_in_t;

  // One result item.
  typedef struct packed {
    logic signed [KEY_W-1:0] top_key;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
    logic [1:0]              status;
  } bhpq_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_PLACE,
    ST_LAST,
    ST_DOWN,
    ST_REPORT
  } bhpq_state_t;

  // Ordering decisions for one tree level.
  typedef struct packed {
    logic key_over_a;
    logic pick_a;
    logic pick_b;
  } bhpq_pick_t;

  // True when key x must sit above key y under the selected order.
  function automatic logic ranks_above(input logic signed [KEY_W-1:0] x,
                                       input logic signed [KEY_W-1:0] y,
                                       input logic                    min_mode);
    ranks_above = min_mode ? (x < y) : (x > y);
  endfunction

endpackage

// ===== rtl/bhpq_sift_cmp.sv =====
// Key comparator for one heap level: decides sift-up moves and the sift-down child pick.
// Depends on bhpq_pkg for the key width, the decision struct and the ordering function.
module bhpq_sift_cmp (
  input  logic                                     min_mode,
  input  logic signed [bhpq_pkg::KEY_W-1:0]        key,
  input  logic signed [bhpq_pkg::KEY_W-1:0]        val_a,
  input  logic signed [bhpq_pkg::KEY_W-1:0]        val_b,
  input  logic                                     a_valid,
  input  logic                                     b_valid,
  output bhpq_pkg::bhpq_pick_t                     pick
);
  import bhpq_pkg::*;

  logic a_over_key;
  logic b_over_key;
  logic b_over_a;

  // All four compares run in parallel; the picks only select among them.
  assign a_over_key = ranks_above(val_a, key, min_mode);
  assign b_over_key = ranks_above(val_b, key, min_mode);
  assign b_over_a   = ranks_above(val_b, val_a, min_mode);

  // The moving key beats its parent: used while sifting up.
  // The right child wins against whichever of the key and the left child is ahead.
  always_comb begin
    pick.key_over_a = ranks_above(key, val_a, min_mode);
    pick.pick_b     = b_valid && ((a_valid && a_over_key) ? b_over_a : b_over_key);
    pick.pick_a     = a_valid && a_over_key && !pick.pick_b;
  end

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue: one tree level per cycle, set by the store's registered read.
// The result strobe rises as busy falls, so the next item can be transferred at the edge that
// takes the result; no new item is taken before then. Results cannot be stalled.
// Reset (synchronous, active low) empties the queue and selects min order; store not cleared.
module binary_heap_priority_queue #(
  parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::bhpq_in_t  in_data,
  output logic                out_valid,
  output bhpq_pkg::bhpq_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_wdata
);
  import bhpq_pkg::*;

  // Index width covers slot numbers 1 to CAPACITY, which also fits the count.
  localparam int AW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] CAP_C = AW'(CAPACITY);
  localparam logic [AW-1:0] ONE_C = AW'(1);
  localparam logic [AW-1:0] TWO_C = AW'(2);
  localparam logic [AW-1:0] THREE_C = AW'(3);

  bhpq_state_t state_r, state_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] root_r;
  logic [1:0] status_r, status_nxt;
  logic min_mode_r;
  logic out_valid_r, out_valid_nxt;
  bhpq_out_t out_data_r, out_data_nxt;

  // Store ports.
  logic signed [KEY_W-1:0] heap_mem [0:CAPACITY];
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr_a, mem_raddr_b;
  logic signed [KEY_W-1:0] rd_a_r, rd_b_r;

  logic                    accept;
  logic [AW:0]             left_idx, right_idx;
  logic                    left_ok, right_ok;
  logic [AW-1:0]           up_pos;
  logic [AW-1:0]           child;
  logic [AW+COUNT_W-1:0]   count_ext;
  bhpq_pick_t              pick;

  // The order may only change while no item is in flight.
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Children of the hole while sifting down, checked against the count.
  assign left_idx  = {pos_r, 1'b0};
  assign right_idx = {pos_r, 1'b1};
  assign left_ok   = (left_idx <= {1'b0, count_r});
  assign right_ok  = (right_idx <= {1'b0, count_r});
  assign up_pos    = pos_r >> 1;
  assign child     = pick.pick_b ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign count_ext = {{COUNT_W{1'b0}}, count_r};

  // Port a carries the parent or the left child, port b the right child.
  bhpq_sift_cmp u_cmp (
    .min_mode (min_mode_r),
    .key      (key_r),
    .val_a    (rd_a_r),
    .val_b    (rd_b_r),
    .a_valid  (left_ok),
    .b_valid  (right_ok),
    .pick     (pick)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_INSERT) begin
            if (count_r == CAP_C || count_r == '0) state_nxt = ST_REPORT;
            else state_nxt = ST_UP;
          end else begin
            if (count_r == '0 || count_r == ONE_C) state_nxt = ST_REPORT;
            else state_nxt = ST_LAST;
          end
        end
      end
      ST_UP: begin
        if (!pick.key_over_a) state_nxt = ST_REPORT;
        else if (up_pos == ONE_C) state_nxt = ST_PLACE;
      end
      ST_PLACE:  state_nxt = ST_REPORT;
      ST_LAST:   state_nxt = ST_DOWN;
      ST_DOWN: begin
        if (!pick.pick_a && !pick.pick_b) state_nxt = ST_REPORT;
      end
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store accesses and result.
  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = key_r;
    mem_raddr_a   = up_pos >> 1;
    mem_raddr_b   = '0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = STATUS_DONE;
          key_nxt    = in_data.key_in;
          if (in_data.func == FUNC_INSERT) begin
            if (count_r == CAP_C) begin
              status_nxt = STATUS_FULL;
            end else begin
              count_nxt   = count_r + ONE_C;
              pos_nxt     = count_r + ONE_C;
              mem_raddr_a = (count_r + ONE_C) >> 1;
              // First key goes straight to the root.
              if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = ONE_C;
                mem_wdata = in_data.key_in;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_EMPTY;
            end else begin
              count_nxt   = count_r - ONE_C;
              pos_nxt     = ONE_C;
              mem_raddr_a = count_r;
            end
          end
        end
      end
      ST_UP: begin
        mem_we = 1'b1;
        if (pick.key_over_a) begin
          // Parent moves down into the hole.
          mem_wdata = rd_a_r;
          pos_nxt   = up_pos;
        end
      end
      ST_PLACE: begin
        mem_we = 1'b1;
      end
      ST_LAST: begin
        // The last key becomes the moving key; fetch the root's children.
        key_nxt     = rd_a_r;
        mem_raddr_a = TWO_C;
        mem_raddr_b = THREE_C;
      end
      ST_DOWN: begin
        mem_we      = 1'b1;
        mem_raddr_a = {child[AW-2:0], 1'b0};
        mem_raddr_b = {child[AW-2:0], 1'b1};
        if (pick.pick_a || pick.pick_b) begin
          // Winning child moves up into the hole.
          mem_wdata = pick.pick_b ? rd_b_r : rd_a_r;
          pos_nxt   = child;
        end
      end
      ST_REPORT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.top_key     = (count_r != '0) ? root_r : '0;
        out_data_nxt.entry_count = count_ext[COUNT_W-1:0];
        out_data_nxt.is_empty    = (count_r == '0);
        out_data_nxt.status      = status_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_mode_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) min_mode_r <= cfg_wdata;
    end
  end

  // Payload registers; the root copy follows every write to slot one.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (mem_we && mem_waddr == ONE_C) root_r <= mem_wdata;
  end

  // Heap store: one write and two registered reads per cycle, never to the same slot.
  always_ff @(posedge clk) begin
    if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
    rd_a_r <= heap_mem[mem_raddr_a];
    rd_b_r <= heap_mem[mem_raddr_b];
  end

`ifndef NO_ASSERTIONS
  // A result appears only right after the report state.
  a_strobe_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_REPORT))
    else $error("result strobe without report state");

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count exceeds capacity");

  // A transfer makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after an accepted item");

  // A refused insert only happens with a full store.
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STATUS_FULL) |-> (count_r == CAP_C))
    else $error("insert refused while store not full");
`endif

endmodule
